// ===== rtl/core/qtc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qtc_pkg;

    // Default sizes of the name and token stores
    localparam int DEF_NAME_BYTES  = 8;
    localparam int DEF_TOKEN_BYTES = 16;

    // Register port geometry: 64-bit registers at byte address 8*index
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = 3;

    // Width of the byte fields that the registers hold
    localparam int NAME_LEN_W  = 4;
    localparam int TOKEN_LEN_W = 5;
    localparam int TOKEN_LOW_BYTES = 8;

    // Query string separators
    localparam logic [7:0] SEP_CHAR = 8'h26;
    localparam logic [7:0] EQ_CHAR  = 8'h3D;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NAME_BYTES  = 3'd0,
        REG_NAME_LEN    = 3'd1,
        REG_TOKEN_LOW   = 3'd2,
        REG_TOKEN_HIGH  = 3'd3,
        REG_TOKEN_LEN   = 3'd4,
        REG_CONFIGURED  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_VALUE = 2'd1,
        PH_SKIP  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        V_GRANTED = 2'd0,
        V_DENIED  = 2'd1,
        V_ERROR   = 2'd2
    } t_verdict;

    // One input transaction
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/core/qtc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qtc_cfg
    import qtc_pkg::*;
#(
    parameter int NAME_BYTES  = DEF_NAME_BYTES,
    parameter int TOKEN_BYTES = DEF_TOKEN_BYTES,
    localparam int SPW = $clog2(NAME_BYTES + 1),
    localparam int VPW = $clog2(TOKEN_BYTES + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [CFG_ADDR_W-1:0]           paddr,
    input  wire logic [CFG_DATA_W-1:0]           pwdata,
    output logic      [CFG_DATA_W-1:0]           prdata,
    output logic                                 pready,
    output logic      [NAME_BYTES-1:0][7:0]      o_name,
    output logic      [SPW-1:0]                  o_name_len,
    output logic      [TOKEN_BYTES-1:0][7:0]     o_token,
    output logic      [VPW-1:0]                  o_token_len,
    output logic                                 o_configured
);

    logic [NAME_BYTES-1:0][7:0]  r_name;
    logic [TOKEN_BYTES-1:0][7:0] r_token;
    logic [NAME_LEN_W-1:0]       r_name_len;
    logic [TOKEN_LEN_W-1:0]      r_token_len;
    logic                        r_configured;
    logic                        wr_en;
    t_reg_idx                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);

    // Write the addressed register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name       <= '0;
            r_token      <= '0;
            r_name_len   <= '0;
            r_token_len  <= '0;
            r_configured <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NAME_BYTES: begin
                    for (int i = 0; i < NAME_BYTES; i++) begin
                        r_name[i] <= pwdata[8*i +: 8];
                    end
                end
                REG_NAME_LEN:   r_name_len <= pwdata[NAME_LEN_W-1:0];
                REG_TOKEN_LOW: begin
                    for (int i = 0; i < TOKEN_BYTES; i++) begin
                        if (i < TOKEN_LOW_BYTES) begin
                            r_token[i] <= pwdata[8*(i % TOKEN_LOW_BYTES) +: 8];
                        end
                    end
                end
                REG_TOKEN_HIGH: begin
                    for (int i = 0; i < TOKEN_BYTES; i++) begin
                        if (i >= TOKEN_LOW_BYTES) begin
                            r_token[i] <= pwdata[8*(i % TOKEN_LOW_BYTES) +: 8];
                        end
                    end
                end
                REG_TOKEN_LEN:  r_token_len <= pwdata[TOKEN_LEN_W-1:0];
                REG_CONFIGURED: r_configured <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_NAME_BYTES: begin
                for (int i = 0; i < NAME_BYTES; i++) begin
                    prdata[8*i +: 8] = r_name[i];
                end
            end
            REG_NAME_LEN:   prdata[NAME_LEN_W-1:0] = r_name_len;
            REG_TOKEN_LOW: begin
                for (int i = 0; i < TOKEN_BYTES; i++) begin
                    if (i < TOKEN_LOW_BYTES) begin
                        prdata[8*(i % TOKEN_LOW_BYTES) +: 8] = r_token[i];
                    end
                end
            end
            REG_TOKEN_HIGH: begin
                for (int i = 0; i < TOKEN_BYTES; i++) begin
                    if (i >= TOKEN_LOW_BYTES) begin
                        prdata[8*(i % TOKEN_LOW_BYTES) +: 8] = r_token[i];
                    end
                end
            end
            REG_TOKEN_LEN:  prdata[TOKEN_LEN_W-1:0] = r_token_len;
            REG_CONFIGURED: prdata[0] = r_configured;
            default: ;
        endcase
    end

    // Clamp lengths to the store sizes
    assign o_name_len  = (r_name_len > NAME_LEN_W'(NAME_BYTES))
                       ? SPW'(NAME_BYTES) : r_name_len[SPW-1:0];
    assign o_token_len = (r_token_len > TOKEN_LEN_W'(TOKEN_BYTES))
                       ? VPW'(TOKEN_BYTES) : r_token_len[VPW-1:0];

    assign o_name       = r_name;
    assign o_token      = r_token;
    assign o_configured = r_configured;

endmodule

`default_nettype wire

// ===== rtl/core/qtc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qtc_step
    import qtc_pkg::*;
#(
    parameter int NAME_BYTES  = DEF_NAME_BYTES,
    parameter int TOKEN_BYTES = DEF_TOKEN_BYTES,
    localparam int SPW = $clog2(NAME_BYTES + 1),
    localparam int VPW = $clog2(TOKEN_BYTES + 1)
) (
    input  wire t_item                       i_item,
    input  wire logic [SPW-1:0]              i_seg_pos,
    input  wire t_phase                      i_phase,
    input  wire logic [VPW-1:0]              i_val_pos,
    input  wire logic                        i_val_mis,
    input  wire t_verdict                    i_decided,
    input  wire logic [NAME_BYTES-1:0][7:0]  i_name,
    input  wire logic [SPW-1:0]              i_name_len,
    input  wire logic [TOKEN_BYTES-1:0][7:0] i_token,
    input  wire logic [VPW-1:0]              i_token_len,
    input  wire logic                        i_configured,
    output logic      [SPW-1:0]              o_seg_pos,
    output t_phase                           o_phase,
    output logic      [VPW-1:0]              o_val_pos,
    output logic                             o_val_mis,
    output t_verdict                         o_decided,
    output t_verdict                         o_verdict
);

    localparam int NIW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int TIW = (TOKEN_BYTES > 1) ? $clog2(TOKEN_BYTES) : 1;

    logic val_ok;

    // Advance the segment matcher by one query byte
    always_comb begin
        o_seg_pos = i_seg_pos;
        o_phase   = i_phase;
        o_val_pos = i_val_pos;
        o_val_mis = i_val_mis;
        o_decided = i_decided;
        if (i_item.kind == KIND_BYTE) begin
            case (i_phase)
                PH_NAME: begin
                    if (i_item.ch == SEP_CHAR) begin
                        o_seg_pos = '0;
                    end else if (i_seg_pos < i_name_len) begin
                        if (i_item.ch == i_name[i_seg_pos[NIW-1:0]]) begin
                            o_seg_pos = i_seg_pos + SPW'(1);
                        end else begin
                            o_phase = PH_SKIP;
                        end
                    end else if (i_item.ch == EQ_CHAR) begin
                        o_phase   = PH_VALUE;
                        o_val_pos = '0;
                        o_val_mis = 1'b0;
                    end else begin
                        o_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_item.ch == SEP_CHAR) begin
                        o_phase   = PH_NAME;
                        o_seg_pos = '0;
                    end
                end
                PH_VALUE: begin
                    if (i_item.ch == SEP_CHAR) begin
                        o_decided = (!i_val_mis && i_val_pos == i_token_len)
                                  ? V_GRANTED : V_DENIED;
                        o_phase   = PH_DONE;
                    end else begin
                        // Past the token end every byte is a mismatch
                        if (i_val_pos >= i_token_len ||
                            i_item.ch != i_token[i_val_pos[TIW-1:0]]) begin
                            o_val_mis = 1'b1;
                        end
                        if (i_val_pos < VPW'(TOKEN_BYTES)) begin
                            o_val_pos = i_val_pos + VPW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign val_ok = !o_val_mis && (o_val_pos == i_token_len);

    // Form the verdict from the updated state
    always_comb begin
        if (i_item.kind != KIND_BYTE && i_item.kind != KIND_EMPTY) begin
            o_verdict = V_DENIED;
        end else if (!i_configured) begin
            o_verdict = V_ERROR;
        end else begin
            case (o_phase)
                PH_DONE:  o_verdict = o_decided;
                PH_VALUE: o_verdict = val_ok ? V_GRANTED : V_DENIED;
                default:  o_verdict = V_DENIED;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/query_token_check.sv =====
// query_token_check: streaming check of a URL query string parameter.
// Input channel (i_in_valid / o_in_ready) carries one transaction per query
// byte, or an empty / absent query string marker; i_last ends the request.
// Output channel (o_out_valid / i_out_ready) carries one verdict per request,
// produced for the transaction that has i_last set: granted, denied or
// general error.
// The last transaction passes through the input register, its verdict through
// the result register. Throughput: one transaction per cycle unless a last
// one waits, set by the byte compare and counter update between them.
// When the receiver stalls, the result register holds its verdict; the input
// register keeps taking transactions that end no request, and the final
// transaction of the next request waits there until the result is taken.
// Reset (synchronous, active low) clears the state registers, so it reads
// as unconfigured and the request state returns to matching the name.
// Registers are written over the APB port, 64-bit, at byte address 8*index,
// and are meant to be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module query_token_check
    import qtc_pkg::*;
#(
    parameter int NAME_BYTES  = DEF_NAME_BYTES,
    parameter int TOKEN_BYTES = DEF_TOKEN_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_item_kind,
    input  wire logic [7:0]            i_ch,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [1:0]            o_verdict,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SPW = $clog2(NAME_BYTES + 1);
    localparam int VPW = $clog2(TOKEN_BYTES + 1);

    logic [NAME_BYTES-1:0][7:0]  cfg_name;
    logic [SPW-1:0]              cfg_name_len;
    logic [TOKEN_BYTES-1:0][7:0] cfg_token;
    logic [VPW-1:0]              cfg_token_len;
    logic                        cfg_configured;

    logic     r_in_valid;
    t_item    r_item;
    logic     advance;
    logic     in_fire;

    logic [SPW-1:0] r_seg_pos, n_seg_pos;
    t_phase         r_phase, n_phase;
    logic [VPW-1:0] r_val_pos, n_val_pos;
    logic           r_val_mis, n_val_mis;
    t_verdict       r_decided, n_decided;
    t_verdict       step_verdict;

    logic     r_out_valid;
    t_verdict r_verdict;

    qtc_cfg #(
        .NAME_BYTES  (NAME_BYTES),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_name       (cfg_name),
        .o_name_len   (cfg_name_len),
        .o_token      (cfg_token),
        .o_token_len  (cfg_token_len),
        .o_configured (cfg_configured)
    );

    // Process the held transaction unless it ends a request and the result
    // register is still occupied
    assign advance    = r_in_valid && (!r_item.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.kind <= i_item_kind;
            r_item.ch   <= i_ch;
            r_item.last <= i_last;
        end
    end

    qtc_step #(
        .NAME_BYTES  (NAME_BYTES),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_step (
        .i_item       (r_item),
        .i_seg_pos    (r_seg_pos),
        .i_phase      (r_phase),
        .i_val_pos    (r_val_pos),
        .i_val_mis    (r_val_mis),
        .i_decided    (r_decided),
        .i_name       (cfg_name),
        .i_name_len   (cfg_name_len),
        .i_token      (cfg_token),
        .i_token_len  (cfg_token_len),
        .i_configured (cfg_configured),
        .o_seg_pos    (n_seg_pos),
        .o_phase      (n_phase),
        .o_val_pos    (n_val_pos),
        .o_val_mis    (n_val_mis),
        .o_decided    (n_decided),
        .o_verdict    (step_verdict)
    );

    // Request state: update per transaction, clear at the end of a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_pos <= '0;
            r_phase   <= PH_NAME;
            r_val_pos <= '0;
            r_val_mis <= 1'b0;
            r_decided <= V_DENIED;
        end else if (advance) begin
            if (r_item.last) begin
                r_seg_pos <= '0;
                r_phase   <= PH_NAME;
                r_val_pos <= '0;
                r_val_mis <= 1'b0;
                r_decided <= V_DENIED;
            end else begin
                r_seg_pos <= n_seg_pos;
                r_phase   <= n_phase;
                r_val_pos <= n_val_pos;
                r_val_mis <= n_val_mis;
                r_decided <= n_decided;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item.last) begin
            r_verdict <= step_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

`default_nettype wire

// ===== tb/tb_query_token_check.sv =====
`timescale 1ns / 1ps

module tb_query_token_check;
    import qtc_pkg::*;

    // Reserved item kind, treated like an absent query string
    localparam logic [1:0] KIND_RSVD = 2'd3;
    // Cycles with no transaction on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // Random query transactions per register setup
    localparam int PHASE_ITEMS = 95;
    localparam int PHASE_COUNT = 10;

    typedef struct {
        logic [63:0] name_word;
        logic [3:0]  name_len;
        logic [63:0] tok_lo;
        logic [63:0] tok_hi;
        logic [4:0]  tok_len;
        logic        enable;
    } qtc_setup_t;

    // Predict the verdict of each request and check the block's verdicts in order
    class qtc_verdict_tracker;
        logic [63:0] name_word = '0;
        logic [3:0]  name_len  = '0;
        logic [63:0] tok_lo    = '0;
        logic [63:0] tok_hi    = '0;
        logic [4:0]  tok_len   = '0;
        logic        cfg_ok    = 1'b0;

        logic [4:0]  seg_pos   = '0;
        t_phase      phase     = PH_NAME;
        logic [4:0]  val_pos   = '0;
        logic        val_bad   = 1'b0;
        t_verdict    held      = V_DENIED;

        t_verdict    due_verdicts[$];
        int          errors    = 0;
        int          items     = 0;
        int          checked   = 0;
        int          n_granted = 0;
        int          n_denied  = 0;
        int          n_error   = 0;

        function void set_reg(t_reg_idx idx, logic [63:0] val);
            case (idx)
                REG_NAME_BYTES: name_word = val;
                REG_NAME_LEN:   name_len  = val[3:0];
                REG_TOKEN_LOW:  tok_lo    = val;
                REG_TOKEN_HIGH: tok_hi    = val;
                REG_TOKEN_LEN:  tok_len   = val[4:0];
                REG_CONFIGURED: cfg_ok    = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned name_eff();
            if (name_len > DEF_NAME_BYTES) return DEF_NAME_BYTES;
            return name_len;
        endfunction

        function int unsigned tok_eff();
            if (tok_len > DEF_TOKEN_BYTES) return DEF_TOKEN_BYTES;
            return tok_len;
        endfunction

        function logic [7:0] tok_byte(logic [4:0] i);
            logic [63:0] w;
            if (i < 5'd8) w = tok_lo;
            else w = tok_hi;
            return w[i[2:0]*8 +: 8];
        endfunction

        function t_verdict value_verdict();
            if (!val_bad && val_pos == tok_eff()) return V_GRANTED;
            return V_DENIED;
        endfunction

        // Advance the segment matcher by one query byte
        function void take_byte(logic [7:0] ch);
            int unsigned nl;
            nl = name_eff();
            case (phase)
                PH_NAME: begin
                    if (ch == SEP_CHAR) begin
                        seg_pos = '0;
                    end else if (seg_pos < nl) begin
                        if (ch == name_word[seg_pos*8 +: 8]) seg_pos = seg_pos + 5'd1;
                        else phase = PH_SKIP;
                    end else if (ch == EQ_CHAR) begin
                        phase   = PH_VALUE;
                        val_pos = '0;
                        val_bad = 1'b0;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (ch == SEP_CHAR) begin
                        phase   = PH_NAME;
                        seg_pos = '0;
                    end
                end
                PH_VALUE: begin
                    if (ch == SEP_CHAR) begin
                        held  = value_verdict();
                        phase = PH_DONE;
                    end else begin
                        if (val_pos >= tok_eff() || ch != tok_byte(val_pos)) val_bad = 1'b1;
                        if (val_pos < 5'd31) val_pos = val_pos + 5'd1;
                    end
                end
                default: ;
            endcase
        endfunction

        function t_verdict request_verdict(logic [1:0] kind);
            if (kind != KIND_BYTE && kind != KIND_EMPTY) return V_DENIED;
            if (!cfg_ok) return V_ERROR;
            if (phase == PH_DONE) return held;
            if (phase == PH_VALUE) return value_verdict();
            return V_DENIED;
        endfunction

        // Note an accepted input transaction and queue the verdict it ends with
        function void log_item(logic [1:0] kind, logic [7:0] ch, logic last);
            if (kind == KIND_BYTE) take_byte(ch);
            if (!last) begin
                if (kind == KIND_BYTE) items++;
                return;
            end
            items++;
            due_verdicts.push_back(request_verdict(kind));
            seg_pos = '0;
            phase   = PH_NAME;
            val_pos = '0;
            val_bad = 1'b0;
            held    = V_DENIED;
        endfunction

        // Compare an accepted verdict with the oldest one due
        function void check_verdict(logic [1:0] got);
            t_verdict want;
            checked++;
            if (due_verdicts.size() == 0) begin
                $error("verdict: no verdict due, actual %0d", got);
                errors++;
                return;
            end
            want = due_verdicts.pop_front();
            case (want)
                V_GRANTED: n_granted++;
                V_DENIED:  n_denied++;
                default:   n_error++;
            endcase
            if (got !== want) begin
                $error("verdict mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_item_kind = KIND_BYTE;
    logic [7:0]            i_ch        = '0;
    logic                  i_last      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_verdict;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    qtc_verdict_tracker sb = new;
    qtc_setup_t         cur;
    logic               steady = 1'b0;
    int                 setups = 0;
    int                 quiet  = 0;

    query_token_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item_kind (i_item_kind),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Take verdicts and stall the receiver at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_verdict(o_verdict);
        i_out_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    // Abandon the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Random byte that favors the separators
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return SEP_CHAR;
        if (r < 45) return EQ_CHAR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly lowercase letters, sometimes any byte
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 8; i++) w[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 25));
        end
        return w;
    endfunction

    function automatic qtc_setup_t make_setup(int p);
        qtc_setup_t s;
        s.name_word = rand_word();
        s.tok_lo    = rand_word();
        s.tok_hi    = rand_word();
        s.name_len  = 4'($urandom_range(0, DEF_NAME_BYTES));
        s.tok_len   = 5'($urandom_range(0, DEF_TOKEN_BYTES));
        s.enable    = 1'b1;
        if ($urandom_range(0, 9) == 0) s.name_len = 4'($urandom_range(DEF_NAME_BYTES + 1, 15));
        if ($urandom_range(0, 9) == 0) s.tok_len = 5'($urandom_range(DEF_TOKEN_BYTES + 1, 31));
        case (p)
            // all ones at full length
            0: begin
                s.name_word = '1;
                s.name_len  = 4'(DEF_NAME_BYTES);
                s.tok_lo    = '1;
                s.tok_hi    = '1;
                s.tok_len   = 5'(DEF_TOKEN_BYTES);
            end
            // empty name and empty token
            1: begin
                s.name_word = '0;
                s.name_len  = '0;
                s.tok_lo    = '0;
                s.tok_hi    = '0;
                s.tok_len   = '0;
            end
            // lengths beyond the stores
            2: begin
                s.name_len = '1;
                s.tok_len  = '1;
            end
            // name holding a separator can never match
            3: begin
                s.name_word = 64'h0000_0000_0062_2661;
                s.name_len  = 4'd3;
            end
            4: s.enable = 1'b0;
            default: ;
        endcase
        return s;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_setup(qtc_setup_t s);
        reg_write(REG_NAME_BYTES, s.name_word);
        reg_write(REG_NAME_LEN, 64'(s.name_len));
        reg_write(REG_TOKEN_LOW, s.tok_lo);
        reg_write(REG_TOKEN_HIGH, s.tok_hi);
        reg_write(REG_TOKEN_LEN, 64'(s.tok_len));
        reg_write(REG_CONFIGURED, 64'(s.enable));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur = s;
        setups++;
    endtask

    // Stop sending, wait for every due verdict, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one input transaction and hold it until accepted
    task automatic send_item(logic [1:0] kind, logic [7:0] ch, logic last);
        while (!steady && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_item_kind <= kind;
        i_ch        <= ch;
        i_last      <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.log_item(kind, ch, last);
    endtask

    // Send query bytes and end the request with the given kind
    task automatic send_seq(input logic [7:0] q[$], input logic [1:0] tail);
        foreach (q[i]) send_item(KIND_BYTE, q[i], tail == KIND_BYTE && i == q.size() - 1);
        if (tail != KIND_BYTE) begin
            send_item(tail, 8'($urandom_range(0, 255)), 1'b1);
        end else if (q.size() == 0) begin
            send_item(KIND_EMPTY, 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Build one request, mostly well-formed segments against the current setup
    task automatic send_request();
        logic [7:0] q[$];
        int         nl;
        int         tl;
        int         r;
        int         vlen;
        int         p;
        logic [1:0] tail;
        nl = (cur.name_len > DEF_NAME_BYTES) ? DEF_NAME_BYTES : cur.name_len;
        tl = (cur.tok_len > DEF_TOKEN_BYTES) ? DEF_TOKEN_BYTES : cur.tok_len;
        if ($urandom_range(0, 9) == 0) begin
            send_item(2'($urandom_range(KIND_EMPTY, KIND_RSVD)), 8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(0, 12)) q.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if (q.size() != 0) q.push_back(SEP_CHAR);
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    // matching name, then a value close to the token
                    for (int i = 0; i < nl; i++) q.push_back(cur.name_word[i*8 +: 8]);
                    q.push_back(EQ_CHAR);
                    r    = $urandom_range(0, 4);
                    vlen = (r == 2) ? $urandom_range(0, tl) : tl;
                    for (int i = 0; i < vlen; i++) begin
                        if (i < 8) q.push_back(cur.tok_lo[i*8 +: 8]);
                        else q.push_back(cur.tok_hi[(i - 8)*8 +: 8]);
                    end
                    if (r == 3) repeat ($urandom_range(1, 3)) q.push_back(noise_byte());
                    if (r == 4 && vlen > 0) begin
                        p    = q.size() - 1 - $urandom_range(0, vlen - 1);
                        q[p] = q[p] ^ (8'd1 << $urandom_range(0, 7));
                    end
                end else if (r < 8) begin
                    // name prefix broken by a stray byte
                    p = $urandom_range(0, nl);
                    for (int i = 0; i < p; i++) q.push_back(cur.name_word[i*8 +: 8]);
                    q.push_back(noise_byte());
                end else begin
                    repeat ($urandom_range(0, 5)) q.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        r = $urandom_range(0, 9);
        if (r < 7) tail = KIND_BYTE;
        else if (r == 7) tail = KIND_EMPTY;
        else if (r == 8) tail = KIND_NONE;
        else tail = KIND_RSVD;
        send_seq(q, tail);
    endtask

    initial begin
        qtc_setup_t s;
        int         target;
        logic       paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unconfigured block after reset
        send_item(KIND_BYTE, 8'h6B, 1'b1);
        send_item(KIND_NONE, 8'h00, 1'b1);
        send_item(KIND_EMPTY, 8'hFF, 1'b1);
        drain();

        // Name "k", token of bytes FF then 00
        s = '{name_word: 64'h6B, name_len: 4'd1, tok_lo: 64'hFF, tok_hi: '1,
              tok_len: 5'd2, enable: 1'b1};
        write_setup(s);
        send_seq('{8'h6B, EQ_CHAR, 8'hFF, 8'h00}, KIND_BYTE);
        send_seq('{8'h6B, EQ_CHAR, 8'hFF}, KIND_BYTE);
        send_seq('{8'h6B, EQ_CHAR, 8'hFF, 8'h00, 8'hFF}, KIND_BYTE);
        send_seq('{SEP_CHAR, 8'h6B, EQ_CHAR, 8'hFF, 8'h00, SEP_CHAR}, KIND_BYTE);
        send_item(KIND_EMPTY, 8'h00, 1'b0);
        send_item(KIND_EMPTY, 8'h00, 1'b1);
        send_seq('{8'h6B}, KIND_RSVD);

        // Random requests under a series of setups
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            write_setup(make_setup(p));
            steady = (p == 2);
            target = sb.items + PHASE_ITEMS;
            while (sb.items < target) begin
                send_request();
                if (p == 5 && !paused && sb.items > target - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;
        drain();

        $display("Covered %0d query transactions and %0d verdicts across %0d register setups",
                 sb.items, sb.checked, setups);
        $display("Verdicts due: %0d granted, %0d denied, %0d general error; %0d mismatches",
                 sb.n_granted, sb.n_denied, sb.n_error, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qtc_pkg.sv
rtl/core/qtc_cfg.sv
rtl/core/qtc_step.sv
rtl/core/query_token_check.sv
tb/tb_query_token_check.sv
